### rtl/sbra_pkg.sv
package sbra_pkg;

  // Map geometry: the slot map is kept as rows of one word each.
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int WORDS  = SLOTS / WORD_W;
  localparam int WIDX_W = 5;
  localparam int POP_W  = 6;

  // Request kinds.
  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Result status codes.
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NO_FREE = 1'b1;

  // Summary of one word of the map as seen through a slot window.
  typedef struct packed {
    logic [WORD_W-1:0] bits;
    logic [POP_W-1:0]  cnt;
    logic [BIT_W-1:0]  lowest;
    logic [BIT_W-1:0]  highest;
    logic              any;
  } sbra_word_t;

endpackage

### rtl/sbra_ram.sv
module sbra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/sbra_word_unit.sv
module sbra_word_unit (
  input  logic [sbra_pkg::WORD_W-1:0] vec,
  input  logic [sbra_pkg::WIDX_W-1:0] widx,
  input  logic [sbra_pkg::CNT_W-1:0]  lo,
  input  logic [sbra_pkg::CNT_W-1:0]  hi,
  output sbra_pkg::sbra_word_t        res
);
  import sbra_pkg::*;

  logic [CNT_W-1:0] slot;

  // Window the word to slots lo..hi, then count and locate the set bits.
  always_comb begin
    res = '0;
    slot = '0;
    for (int b = 0; b < WORD_W; b++) begin
      slot = {1'b0, widx, BIT_W'(b)};
      res.bits[b] = vec[b] && (slot >= lo) && (slot <= hi);
      res.cnt = res.cnt + POP_W'(res.bits[b]);
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (res.bits[b]) begin
        res.lowest = BIT_W'(b);
      end
    end
    for (int b = 0; b < WORD_W; b++) begin
      if (res.bits[b]) begin
        res.highest = BIT_W'(b);
      end
    end
    res.any = |res.bits;
  end

endmodule

### rtl/slot_bitmap_range_allocator.sv
// Slot range allocator over a 1024-slot occupancy map held as 32 rows of 32
// bits in a RAM. One request is worked at a time: a shared word unit windows,
// counts and locates bits of one row per visit (RAM read, then evaluate and
// write back), walking from the row of the first slot to the row of the last
// managed (place) or last cleared slot. A place whose amount runs out inside
// a row walks that row bit by bit to find the exact end slot. Out-of-range
// requests go straight to the result without reading the RAM. in_stall is
// high from the accepted beat until its result beat is taken. The map is
// free after reset without any clearing pass.
module slot_bitmap_range_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sbra_pkg::CNT_W-1:0]  cfg_slots_in_use,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [sbra_pkg::SLOT_W-1:0] in_first_slot_in,
  input  logic [sbra_pkg::CNT_W-1:0]  in_amount_or_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [sbra_pkg::SLOT_W-1:0] out_placed_first,
  output logic [sbra_pkg::SLOT_W-1:0] out_placed_last,
  output logic [sbra_pkg::CNT_W-1:0]  out_freed_count
);
  import sbra_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  slots_r;
  logic [WIDX_W-1:0] w_r, w_nxt, wlast_r, wlast_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic              act_r, act_nxt;
  logic              started_r, started_nxt;
  logic [SLOT_W-1:0] start_r, start_nxt, end_r, end_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt, cnt_r, cnt_nxt;
  logic [WORD_W-1:0] row_r, row_nxt, free_r, free_nxt;
  logic [BIT_W-1:0]  b_r, b_nxt;
  logic [WORDS-1:0]  rowv_r, rowv_nxt;
  logic              rdv_r;
  logic              ov_r, ov_nxt, ost_r, ost_nxt;
  logic [SLOT_W-1:0] opf_r, opf_nxt, opl_r, opl_nxt;
  logic [CNT_W-1:0]  ofc_r, ofc_nxt;

  logic              wr_en;
  logic [WORD_W-1:0] wr_data, ram_q, q, unit_vec;
  logic [CNT_W-1:0]  n, amt, last_c;
  sbra_word_t        wu;

  sbra_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (w_r),
    .wr_data (wr_data),
    .rd_addr (w_r),
    .rd_data (ram_q)
  );

  // Rows never written since reset read as free.
  assign q = rdv_r ? ram_q : '0;
  assign unit_vec = (act_r == ACT_CLEAR) ? q : ~q;

  sbra_word_unit u_word (
    .vec  (unit_vec),
    .widx (w_r),
    .lo   (lo_r),
    .hi   (hi_r),
    .res  (wu)
  );

  assign n = (slots_r > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slots_r;
  assign amt = (in_amount_or_last == '0) ? CNT_W'(1) : in_amount_or_last;
  assign last_c = (in_amount_or_last >= n) ? (n - CNT_W'(1)) : in_amount_or_last;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_placed_first = opf_r;
  assign out_placed_last = opl_r;
  assign out_freed_count = ofc_r;

  // Request sequencer.
  always_comb begin
    state_nxt = state_r;
    w_nxt = w_r;
    wlast_nxt = wlast_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    act_nxt = act_r;
    started_nxt = started_r;
    start_nxt = start_r;
    end_nxt = end_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    row_nxt = row_r;
    free_nxt = free_r;
    b_nxt = b_r;
    rowv_nxt = rowv_r;
    ov_nxt = ov_r;
    ost_nxt = ost_r;
    opf_nxt = opf_r;
    opl_nxt = opl_r;
    ofc_nxt = ofc_r;
    wr_en = 1'b0;
    wr_data = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          lo_nxt = {1'b0, in_first_slot_in};
          w_nxt = in_first_slot_in[SLOT_W-1 -: WIDX_W];
          started_nxt = 1'b0;
          cnt_nxt = '0;
          rem_nxt = amt;
          ost_nxt = ST_DONE;
          opf_nxt = '0;
          opl_nxt = '0;
          ofc_nxt = '0;
          if (in_action == ACT_PLACE) begin
            hi_nxt = n - CNT_W'(1);
            wlast_nxt = hi_nxt[SLOT_W-1 -: WIDX_W];
            if ({1'b0, in_first_slot_in} >= n) begin
              ost_nxt = ST_NO_FREE;
              ov_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_RD;
            end
          end else begin
            hi_nxt = last_c;
            wlast_nxt = last_c[SLOT_W-1 -: WIDX_W];
            if (n == '0 || {1'b0, in_first_slot_in} >= n ||
                in_amount_or_last < {1'b0, in_first_slot_in}) begin
              ov_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (act_r == ACT_CLEAR) begin
          // Free the windowed occupied bits and tally them.
          wr_en = 1'b1;
          wr_data = q & ~wu.bits;
          cnt_nxt = cnt_r + CNT_W'(wu.cnt);
          if (w_r == wlast_r) begin
            ofc_nxt = cnt_nxt;
            ov_nxt = 1'b1;
            state_nxt = S_OUT;
          end else begin
            w_nxt = w_r + WIDX_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          started_nxt = started_r | wu.any;
          if (!started_r && wu.any) begin
            start_nxt = {w_r, wu.lowest};
          end
          if (started_nxt && CNT_W'(wu.cnt) >= rem_r) begin
            // The end slot lies in this row: walk it bit by bit.
            row_nxt = q;
            free_nxt = wu.bits;
            b_nxt = '0;
            state_nxt = S_SCAN;
          end else begin
            wr_en = 1'b1;
            wr_data = q | wu.bits;
            rem_nxt = rem_r - CNT_W'(wu.cnt);
            if (wu.any) begin
              end_nxt = {w_r, wu.highest};
            end
            if (w_r == wlast_r) begin
              ost_nxt = started_nxt ? ST_DONE : ST_NO_FREE;
              opf_nxt = started_nxt ? start_nxt : '0;
              opl_nxt = started_nxt ? end_nxt : '0;
              ov_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              w_nxt = w_r + WIDX_W'(1);
              state_nxt = S_RD;
            end
          end
        end
      end
      S_SCAN: begin
        if (free_r[b_r]) begin
          row_nxt[b_r] = 1'b1;
          rem_nxt = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            wr_en = 1'b1;
            wr_data = row_nxt;
            ost_nxt = ST_DONE;
            opf_nxt = start_r;
            opl_nxt = {w_r, b_r};
            ov_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end
        b_nxt = b_r + BIT_W'(1);
      end
      S_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (wr_en) begin
      rowv_nxt[w_r] = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slots_r <= CNT_W'(SLOTS);
      rowv_r <= '0;
      rdv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        slots_r <= cfg_slots_in_use;
      end
      rowv_r <= rowv_nxt;
      rdv_r <= rowv_r[w_r];
      ov_r <= ov_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    wlast_r <= wlast_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    act_r <= act_nxt;
    started_r <= started_nxt;
    start_r <= start_nxt;
    end_r <= end_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    row_r <= row_nxt;
    free_r <= free_nxt;
    b_r <= b_nxt;
    ost_r <= ost_nxt;
    opf_r <= opf_nxt;
    opl_r <= opl_nxt;
    ofc_r <= ofc_nxt;
  end

endmodule
